FILE: src/windowed_min_max_mean_unit_defines.svh
// ----------------------------------------------------------------------------
// windowed min/max/mean unit assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MIN_MAX_MEAN_UNIT_DEFINES_SVH
`define WINDOWED_MIN_MAX_MEAN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WMM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wmm: same-cycle check failed");

// next-cycle implication
`define WMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wmm: next-cycle check failed");

`else

`define WMM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define WMM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/wmm_pkg.sv
// ----------------------------------------------------------------------------
// wmm_pkg
// widths and constants shared by the windowed min/max/mean unit
// ----------------------------------------------------------------------------
package wmm_pkg;

  localparam int DATA_W      = 32;
  localparam int SUM_W       = 48;
  localparam int LEN_W       = 16;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // longest window honored, longer settings are clamped to it
  localparam int MAX_WINDOW  = 65535;

  localparam logic [LEN_W-1:0] SHORT_WINDOW = 16'd10;
  localparam logic [LEN_W-1:0] WINDOW_RESET = 16'd16;
  localparam logic [LEN_W-1:0] COUNT_SAT    = 16'hFFFF;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

endpackage

FILE: src/wmm_div.sv
// ----------------------------------------------------------------------------
// wmm_div
// restoring divider, one quotient bit per cycle, signed sum by unsigned count,
// quotient truncated toward zero
// ----------------------------------------------------------------------------
`include "windowed_min_max_mean_unit_defines.svh"

module wmm_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [wmm_pkg::SUM_W-1:0]       dividend,
  input  logic        [wmm_pkg::LEN_W-1:0]       divisor,
  output logic                                   done,
  output logic signed [wmm_pkg::DATA_W-1:0]      quotient
);

  logic                               busy;
  logic                               fix;
  logic [wmm_pkg::DIV_CNT_W-1:0]      cnt;
  logic                               neg;
  logic [wmm_pkg::LEN_W-1:0]          dvs;
  logic [wmm_pkg::LEN_W-1:0]          rem;
  logic [wmm_pkg::SUM_W-1:0]          quo;

  logic [wmm_pkg::LEN_W:0]            trial;
  logic [wmm_pkg::LEN_W:0]            diff;
  logic                               ge;
  logic [wmm_pkg::SUM_W-1:0]          mag;

  assign mag   = dividend[wmm_pkg::SUM_W-1] ? (-dividend) : dividend;
  assign trial = {rem, quo[wmm_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[wmm_pkg::SUM_W-1];
        dvs  <= divisor;
        rem  <= '0;
        quo  <= mag;
      end else if (busy) begin
        rem <= ge ? diff[wmm_pkg::LEN_W-1:0] : trial[wmm_pkg::LEN_W-1:0];
        quo <= {quo[wmm_pkg::SUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == wmm_pkg::DIV_CNT_W'(wmm_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        // magnitude is at most 2^31, so a 32-bit negate is exact
        quotient <= neg ? (-quo[wmm_pkg::DATA_W-1:0]) : quo[wmm_pkg::DATA_W-1:0];
        done     <= 1'b1;
        fix      <= 1'b0;
      end
    end
  end

  `WMM_ASSERT_IMPLIES(a_no_restart, clk, rst, start, !busy && !fix)
  `WMM_ASSERT_IMPLIES(a_done_after_fix, clk, rst, done, $past(fix))
  `WMM_ASSERT_IMPLIES(a_cnt_range, clk, rst, busy,
                      cnt <= wmm_pkg::DIV_CNT_W'(wmm_pkg::DIV_STEPS - 1))

endmodule

FILE: src/windowed_min_max_mean_unit.sv
// ----------------------------------------------------------------------------
// windowed_min_max_mean_unit
// running min, max and truncated mean over windows of signed 32-bit samples
// ----------------------------------------------------------------------------
// Each accepted sample produces one result item. A sample that does not close
// a window, or closes one of fewer than ten samples, is accepted and then its
// result is loaded into the output register. A sample that closes a window of
// ten or more runs the bit-serial divider: 48 steps plus a sign fix. The result
// register lets a new sample be accepted while the previous result still waits
// on out_ready. The user must write window_length through cfg_we/cfg_data only
// while no item is in flight; the block does not enforce this. Zero acts as one.
`include "windowed_min_max_mean_unit_defines.svh"

module windowed_min_max_mean_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic        [wmm_pkg::LEN_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [wmm_pkg::DATA_W-1:0]     sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wmm_pkg::DATA_W-1:0]     average,
  output logic signed [wmm_pkg::DATA_W-1:0]     minimum,
  output logic signed [wmm_pkg::DATA_W-1:0]     maximum,
  output logic                                  average_valid,
  output logic                                  window_done,
  output logic        [wmm_pkg::LEN_W-1:0]      samples_in_window
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  state_t                               state;
  logic [wmm_pkg::LEN_W-1:0]            window_length;
  logic signed [wmm_pkg::SUM_W-1:0]     running_sum;
  logic [wmm_pkg::LEN_W-1:0]            window_count;
  logic signed [wmm_pkg::DATA_W-1:0]    pending_max;
  logic signed [wmm_pkg::DATA_W-1:0]    pending_min;
  logic signed [wmm_pkg::DATA_W-1:0]    latched_average;
  logic signed [wmm_pkg::DATA_W-1:0]    latched_min;
  logic signed [wmm_pkg::DATA_W-1:0]    latched_max;
  logic                                 valid_flag;
  logic                                 done_flag;

  logic [wmm_pkg::LEN_W-1:0]            eff_len;
  logic signed [wmm_pkg::SUM_W-1:0]     sum_next;
  logic [wmm_pkg::LEN_W-1:0]            count_next;
  logic signed [wmm_pkg::DATA_W-1:0]    max_next;
  logic signed [wmm_pkg::DATA_W-1:0]    min_next;
  logic                                 close;
  logic                                 accept;
  logic                                 div_start;
  logic                                 div_done;
  logic signed [wmm_pkg::DATA_W-1:0]    div_quotient;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (32'(window_length) > wmm_pkg::MAX_WINDOW) begin
      eff_len = wmm_pkg::LEN_W'(wmm_pkg::MAX_WINDOW);
    end else begin
      eff_len = window_length;
    end
  end

  assign sum_next   = running_sum + {{(wmm_pkg::SUM_W-wmm_pkg::DATA_W){sample[wmm_pkg::DATA_W-1]}},
                                     sample};
  // count saturates rather than wrapping
  assign count_next = (window_count != wmm_pkg::COUNT_SAT) ? window_count + 1'b1 : window_count;
  assign max_next   = (sample > pending_max) ? sample : pending_max;
  assign min_next   = (sample < pending_min) ? sample : pending_min;
  assign close      = count_next >= eff_len;
  assign div_start  = accept && close && (count_next >= wmm_pkg::SHORT_WINDOW);

  wmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (count_next),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      window_length   <= wmm_pkg::WINDOW_RESET;
      running_sum     <= '0;
      window_count    <= '0;
      pending_max     <= wmm_pkg::INT_MIN;
      pending_min     <= wmm_pkg::INT_MAX;
      latched_average <= '0;
      latched_min     <= wmm_pkg::INT_MAX;
      latched_max     <= wmm_pkg::INT_MIN;
      valid_flag      <= 1'b0;
      done_flag       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length <= cfg_data;
      end
      // s_fin reloads the result register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (close) begin
              latched_min  <= min_next;
              latched_max  <= max_next;
              pending_max  <= wmm_pkg::INT_MIN;
              pending_min  <= wmm_pkg::INT_MAX;
              running_sum  <= '0;
              window_count <= '0;
              valid_flag   <= 1'b1;
              done_flag    <= 1'b1;
              if (div_start) begin
                state <= S_DIV;
              end else begin
                latched_average <= '0;
                state           <= S_FIN;
              end
            end else begin
              running_sum  <= sum_next;
              window_count <= count_next;
              pending_max  <= max_next;
              pending_min  <= min_next;
              done_flag    <= 1'b0;
              state        <= S_FIN;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            latched_average <= div_quotient;
            state           <= S_FIN;
          end
        end

        S_FIN: begin
          // result register free or being emptied this cycle
          if (!out_valid || out_ready) begin
            average           <= latched_average;
            minimum           <= latched_min;
            maximum           <= latched_max;
            average_valid     <= valid_flag;
            window_done       <= done_flag;
            samples_in_window <= window_count;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `WMM_ASSERT_IMPLIES(a_div_window_clear, clk, rst, state == S_DIV,
                      window_count == '0 && running_sum == '0)
  `WMM_ASSERT_NEXT(a_valid_sticky, clk, rst, valid_flag, valid_flag)
  `WMM_ASSERT_IMPLIES(a_done_result, clk, rst, out_valid && window_done,
                      average_valid && samples_in_window == '0)
  `WMM_ASSERT_IMPLIES(a_div_done_state, clk, rst, div_done, state == S_DIV)

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// windowed min/max/mean unit testbench
// drives signed samples under random gaps and output stalls, predicts the
// latched mean, minimum and maximum of each item, and checks every result
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [wmm_pkg::DATA_W-1:0] average;
    logic signed [wmm_pkg::DATA_W-1:0] minimum;
    logic signed [wmm_pkg::DATA_W-1:0] maximum;
    logic                              average_valid;
    logic                              window_done;
    logic [wmm_pkg::LEN_W-1:0]         samples_in_window;
  } stats_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [wmm_pkg::LEN_W-1:0]         cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [wmm_pkg::DATA_W-1:0] sample = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [wmm_pkg::DATA_W-1:0] average;
  logic signed [wmm_pkg::DATA_W-1:0] minimum;
  logic signed [wmm_pkg::DATA_W-1:0] maximum;
  logic                              average_valid;
  logic                              window_done;
  logic [wmm_pkg::LEN_W-1:0]         samples_in_window;

  windowed_min_max_mean_unit dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .sample            (sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .average           (average),
    .minimum           (minimum),
    .maximum           (maximum),
    .average_valid     (average_valid),
    .window_done       (window_done),
    .samples_in_window (samples_in_window)
  );

  always #2 clk = ~clk;

  // window state as the block should hold it
  logic [wmm_pkg::LEN_W-1:0]         win_len;
  logic signed [wmm_pkg::SUM_W-1:0]  acc_sum;
  logic [wmm_pkg::LEN_W-1:0]         acc_count;
  logic signed [wmm_pkg::DATA_W-1:0] run_min;
  logic signed [wmm_pkg::DATA_W-1:0] run_max;
  logic signed [wmm_pkg::DATA_W-1:0] held_avg;
  logic signed [wmm_pkg::DATA_W-1:0] held_min;
  logic signed [wmm_pkg::DATA_W-1:0] held_max;
  logic                              held_valid;

  stats_t pending_stats[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 30;
  int     recv_stall_pct = 30;
  int     hold_request = 0;

  function automatic void clear_window_model();
    win_len    = wmm_pkg::WINDOW_RESET;
    acc_sum    = '0;
    acc_count  = '0;
    run_min    = wmm_pkg::INT_MAX;
    run_max    = wmm_pkg::INT_MIN;
    held_avg   = '0;
    held_min   = wmm_pkg::INT_MAX;
    held_max   = wmm_pkg::INT_MIN;
    held_valid = 1'b0;
  endfunction

  function automatic stats_t fold_sample(logic signed [wmm_pkg::DATA_W-1:0] s);
    stats_t                    r;
    longint                    quotient;
    logic [wmm_pkg::LEN_W-1:0] eff_len;
    logic                      closed;
    acc_sum = acc_sum + s;
    if (acc_count != wmm_pkg::COUNT_SAT) acc_count = acc_count + 1'b1;
    if (s > run_max) run_max = s;
    if (s < run_min) run_min = s;
    eff_len = (win_len > wmm_pkg::MAX_WINDOW) ? wmm_pkg::LEN_W'(wmm_pkg::MAX_WINDOW) : win_len;
    // zero length closes on every item since the count is at least one here
    closed = (acc_count >= eff_len);
    if (closed) begin
      if (acc_count < wmm_pkg::SHORT_WINDOW) begin
        held_avg = '0;
      end else begin
        quotient = longint'(acc_sum) / longint'(acc_count);
        held_avg = quotient[wmm_pkg::DATA_W-1:0];
      end
      held_min   = run_min;
      held_max   = run_max;
      run_min    = wmm_pkg::INT_MAX;
      run_max    = wmm_pkg::INT_MIN;
      acc_count  = '0;
      acc_sum    = '0;
      held_valid = 1'b1;
    end
    r.average           = held_avg;
    r.minimum           = held_min;
    r.maximum           = held_max;
    r.average_valid     = held_valid;
    r.window_done       = closed;
    r.samples_in_window = acc_count;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic signed [wmm_pkg::DATA_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return wmm_pkg::INT_MIN;
      1:       return wmm_pkg::INT_MAX;
      2:       return wmm_pkg::INT_MIN + int'($urandom_range(15));
      3:       return wmm_pkg::INT_MAX - int'($urandom_range(15));
      4, 5:    return int'($urandom_range(200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input logic signed [wmm_pkg::DATA_W-1:0] s);
    int gap;
    gap = pick_gap(send_idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample   <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_stats.push_back(fold_sample(s));
  endtask

  // stop offering items and wait for every outstanding result
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [wmm_pkg::LEN_W-1:0] len);
    quiesce();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_len = len;
  endtask

  // default length, first results show the pre-window extremes, sum past 32 bits
  task automatic test_reset_state();
    send_sample(wmm_pkg::INT_MIN);
    repeat (15) send_sample(wmm_pkg::INT_MAX);
  endtask

  // zero length, longest length, and a length lowered below the current count
  task automatic test_length_corners();
    write_window('0);
    send_sample(wmm_pkg::INT_MIN);
    send_sample(-1);
    write_window(16'hFFFF);
    send_sample(5);
    send_sample(-7);
    send_sample(wmm_pkg::INT_MAX);
    write_window(16'd2);
    send_sample(wmm_pkg::INT_MIN);
  endtask

  task automatic test_random_windows(input int total);
    int                        sent;
    int                        n;
    logic [wmm_pkg::LEN_W-1:0] len;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(9))
        0:       len = '0;
        1:       len = wmm_pkg::LEN_W'($urandom_range(9, 1));
        2:       len = wmm_pkg::SHORT_WINDOW;
        3:       len = wmm_pkg::SHORT_WINDOW - 1'b1;
        default: len = wmm_pkg::LEN_W'($urandom_range(60, 11));
      endcase
      write_window(len);
      case ($urandom_range(3))
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 20; recv_stall_pct = 20; end
        2: begin send_idle_pct = 60; recv_stall_pct = 10; end
        3: begin send_idle_pct = 10; recv_stall_pct = 60; end
      endcase
      n = $urandom_range(80, 30);
      repeat (n) send_sample(rand_sample());
      sent += n;
    end
  endtask

  // long receiver hold-off while the sender streams, so the input stalls
  task automatic test_backpressure();
    write_window(wmm_pkg::SHORT_WINDOW);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 300;
    repeat (40) send_sample(rand_sample());
    quiesce();
  endtask

  initial begin
    clear_window_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_length_corners();
    test_random_windows(1040);
    test_backpressure();
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // output ready, with random stalls and the occasional forced hold-off
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        n = pick_gap(recv_stall_pct);
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    stats_t want;
    stats_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{average, minimum, maximum, average_valid, window_done, samples_in_window};
      if (pending_stats.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result item: avg=%0d min=%0d max=%0d", average, minimum,
                   maximum);
        mismatch_count++;
      end else begin
        want = pending_stats.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected avg=%0d min=%0d max=%0d vld=%b done=%b cnt=%0d",
                     want.average, want.minimum, want.maximum, want.average_valid,
                     want.window_done, want.samples_in_window);
            $display("          actual   avg=%0d min=%0d max=%0d vld=%b done=%b cnt=%0d",
                     got.average, got.minimum, got.maximum, got.average_valid,
                     got.window_done, got.samples_in_window);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

FILE: sim.f
+incdir+src
src/wmm_pkg.sv
src/wmm_div.sv
src/windowed_min_max_mean_unit.sv
tb/testbench.sv
